// ===== hdl/rrt_pkg.sv =====
package rrt_pkg;

    localparam int RING_DEPTH = 64;
    localparam int RIDX_W     = $clog2(RING_DEPTH);
    localparam int RSIZE_W    = $clog2(RING_DEPTH + 1);
    localparam int ADDR_W     = 4;
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        MODE_SERVICE = 2'd0,
        MODE_START   = 2'd1,
        MODE_CLEAR   = 2'd2,
        MODE_ABORT   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REASON_NONE   = 2'd0,
        REASON_TERM   = 2'd1,
        REASON_LENGTH = 2'd2,
        REASON_ABORT  = 2'd3
    } t_reason;

    typedef enum logic [1:0] {
        REG_EOF_MODE  = 2'd0,
        REG_TERM_A    = 2'd1,
        REG_TERM_B    = 2'd2,
        REG_RING_SIZE = 2'd3
    } t_reg;

    typedef struct packed {
        t_mode       mode;
        logic        rx_present;
        logic [7:0]  rx_byte;
        logic [15:0] request_length;
    } t_item;

    typedef struct packed {
        logic                eof_mode;
        logic [31:0]         terminators_a;
        logic [31:0]         terminators_b;
        logic [RSIZE_W-1:0]  ring_size;
        logic                ring_reset;
    } t_cfg;

    function automatic logic [RSIZE_W-1:0] rrt_clamp(input logic [6:0] v);
        logic [RSIZE_W-1:0] r;
        if (v < 7'd2) begin
            r = RSIZE_W'(2);
        end else if (32'(v) > RING_DEPTH) begin
            r = RSIZE_W'(RING_DEPTH);
        end else begin
            r = RSIZE_W'(v);
        end
        return r;
    endfunction

    function automatic logic [RIDX_W-1:0] rrt_advance(input logic [RIDX_W-1:0] idx,
                                                      input logic [RSIZE_W-1:0] size);
        logic [RSIZE_W-1:0] n;
        n = RSIZE_W'(idx) + RSIZE_W'(1);
        return (n >= size) ? RIDX_W'(0) : n[RIDX_W-1:0];
    endfunction

    function automatic logic [RSIZE_W-1:0] rrt_held(input logic [RIDX_W-1:0] w,
                                                    input logic [RIDX_W-1:0] r,
                                                    input logic [RSIZE_W-1:0] size);
        logic [RSIZE_W-1:0] h;
        if (w >= r) begin
            h = RSIZE_W'(w) - RSIZE_W'(r);
        end else begin
            h = size + RSIZE_W'(w) - RSIZE_W'(r);
        end
        return h;
    endfunction

endpackage

// ===== hdl/rx_ring_terminated_reader_top.sv =====
// Channel   Direction  Handshake               Payload
// input     in         i_in_valid/o_in_stall   i_mode i_rx_present i_rx_byte i_request_length
// output    out        o_out_valid/i_out_stall o_rx_taken o_deliver_valid o_deliver_byte
//                                              o_request_done o_done_reason o_delivered_count
//                                              o_bytes_available o_request_ignored
// config    in/out     APB psel/penable/pready eof_mode, terminators_a/b, ring_size
//
// One item per cycle sustained while i_out_stall is low; an accepted item is
// written into the input queue, then the back end loads the output register.
// The ring pass is combinational: push, head byte, eight terminator compares.
// Reset is synchronous, active low; the ring contents need no clearing.
// An output stall fills the two-entry input queue before o_in_stall rises.
module rx_ring_terminated_reader_top
    import rrt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [1:0]        i_mode,
    input  logic              i_rx_present,
    input  logic [7:0]        i_rx_byte,
    input  logic [15:0]       i_request_length,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_rx_taken,
    output logic              o_deliver_valid,
    output logic [7:0]        o_deliver_byte,
    output logic              o_request_done,
    output logic [1:0]        o_done_reason,
    output logic [15:0]       o_delivered_count,
    output logic [5:0]        o_bytes_available,
    output logic              o_request_ignored
);

    logic               r_eof_mode;
    logic [31:0]        r_term_a;
    logic [31:0]        r_term_b;
    logic [6:0]         r_size_raw;
    logic [RSIZE_W-1:0] r_size;
    logic               r_ring_reset;
    logic               wr_en;
    t_reg               reg_sel;
    logic [RSIZE_W-1:0] new_size;
    t_cfg               cfg;
    logic               q_valid;
    t_item              q_item;
    logic               q_pop;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite;
    assign reg_sel  = t_reg'(paddr[ADDR_W-1:2]);
    assign new_size = rrt_clamp(pwdata[6:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eof_mode   <= 1'b0;
            r_term_a     <= 32'd0;
            r_term_b     <= 32'd0;
            r_size_raw   <= 7'd64;
            r_size       <= rrt_clamp(7'd64);
            r_ring_reset <= 1'b0;
        end else begin
            r_ring_reset <= 1'b0;
            if (wr_en) begin
                case (reg_sel)
                    REG_EOF_MODE: r_eof_mode <= pwdata[0];
                    REG_TERM_A:   r_term_a   <= pwdata;
                    REG_TERM_B:   r_term_b   <= pwdata;
                    REG_RING_SIZE: begin
                        r_size_raw <= pwdata[6:0];
                        r_size     <= new_size;
                        if (new_size != r_size) begin
                            r_ring_reset <= 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (reg_sel)
            REG_EOF_MODE:  prdata = {31'd0, r_eof_mode};
            REG_TERM_A:    prdata = r_term_a;
            REG_TERM_B:    prdata = r_term_b;
            REG_RING_SIZE: prdata = {25'd0, r_size_raw};
            default:       prdata = 32'd0;
        endcase
    end

    assign cfg.eof_mode      = r_eof_mode;
    assign cfg.terminators_a = r_term_a;
    assign cfg.terminators_b = r_term_b;
    assign cfg.ring_size     = r_size;
    assign cfg.ring_reset    = r_ring_reset;

    rrt_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (i_mode),
        .i_rx_present     (i_rx_present),
        .i_rx_byte        (i_rx_byte),
        .i_request_length (i_request_length),
        .o_q_valid        (q_valid),
        .o_q_item         (q_item),
        .i_q_pop          (q_pop)
    );

    rrt_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_q_pop           (q_pop),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_rx_taken        (o_rx_taken),
        .o_deliver_valid   (o_deliver_valid),
        .o_deliver_byte    (o_deliver_byte),
        .o_request_done    (o_request_done),
        .o_done_reason     (o_done_reason),
        .o_delivered_count (o_delivered_count),
        .o_bytes_available (o_bytes_available),
        .o_request_ignored (o_request_ignored)
    );

endmodule

// ===== hdl/rrt_front.sv =====
module rrt_front
    import rrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic        i_rx_present,
    input  logic [7:0]  i_rx_byte,
    input  logic [15:0] i_request_length,
    output logic        o_q_valid,
    output t_item       o_q_item,
    input  logic        i_q_pop
);

    t_item r_q [QUEUE_DEPTH];
    logic  r_wp;
    logic  r_rp;
    logic [1:0] r_cnt;
    logic  push;
    logic  pop;
    t_item item;

    always_comb begin
        item.mode           = t_mode'(i_mode);
        item.rx_present     = i_rx_present;
        item.rx_byte        = i_rx_byte;
        item.request_length = i_request_length;
    end

    assign o_in_stall = (r_cnt == 2'(QUEUE_DEPTH));
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_item   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

endmodule

// ===== hdl/rrt_back.sv =====
module rrt_back
    import rrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_q_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_rx_taken,
    output logic        o_deliver_valid,
    output logic [7:0]  o_deliver_byte,
    output logic        o_request_done,
    output logic [1:0]  o_done_reason,
    output logic [15:0] o_delivered_count,
    output logic [5:0]  o_bytes_available,
    output logic        o_request_ignored
);

    logic [7:0]        r_ring [RING_DEPTH];
    logic [7:0]        r_head;
    logic [RIDX_W-1:0] r_wr;
    logic [RIDX_W-1:0] r_rd;
    logic              r_active;
    logic [15:0]       r_count;
    logic [15:0]       r_len;
    logic              r_out_valid;

    logic [RIDX_W-1:0] n_wr;
    logic [RIDX_W-1:0] n_rd;
    logic              n_active;
    logic [15:0]       n_count;
    logic [15:0]       n_len;

    logic              fire;
    logic              push;
    logic [RIDX_W-1:0] wr_adv;
    logic [RIDX_W-1:0] wr1;
    logic [RSIZE_W-1:0] held1;
    logic [RSIZE_W-1:0] held_f;
    logic [7:0]        head;
    logic              term_hit;
    logic              dvalid;
    logic [7:0]        dbyte;
    logic              done;
    t_reason           reason;
    logic              ignored;

    assign fire    = i_q_valid && (!r_out_valid || !i_out_stall);
    assign o_q_pop = fire;

    always_comb begin
        wr_adv = rrt_advance(r_wr, i_cfg.ring_size);
        push   = fire && i_q_item.rx_present && (wr_adv != r_rd);
        wr1    = push ? wr_adv : r_wr;
        held1  = rrt_held(wr1, r_rd, i_cfg.ring_size);
        head   = (push && (r_wr == r_rd)) ? i_q_item.rx_byte : r_head;

        term_hit = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (i_cfg.terminators_a[8*k +: 8] == head) begin
                term_hit = 1'b1;
            end
            if (i_cfg.terminators_b[8*k +: 8] == head) begin
                term_hit = 1'b1;
            end
        end
        term_hit = term_hit && i_cfg.eof_mode;

        n_wr     = wr1;
        n_rd     = r_rd;
        n_active = r_active;
        n_count  = r_count;
        n_len    = r_len;
        dvalid   = 1'b0;
        dbyte    = 8'd0;
        done     = 1'b0;
        reason   = REASON_NONE;
        ignored  = 1'b0;

        if (fire) begin
            case (i_q_item.mode)
                MODE_SERVICE: begin
                    if (r_active && (held1 != RSIZE_W'(0))) begin
                        n_rd    = rrt_advance(r_rd, i_cfg.ring_size);
                        n_count = r_count + 16'd1;
                        dvalid  = 1'b1;
                        dbyte   = head;
                        if (term_hit) begin
                            done     = 1'b1;
                            reason   = REASON_TERM;
                            n_active = 1'b0;
                        end else if (n_count == r_len) begin
                            done     = 1'b1;
                            reason   = REASON_LENGTH;
                            n_active = 1'b0;
                        end
                    end
                end
                MODE_START: begin
                    if (r_active) begin
                        ignored = 1'b1;
                    end else begin
                        n_active = 1'b1;
                        n_count  = 16'd0;
                        n_len    = i_q_item.request_length;
                    end
                end
                MODE_CLEAR: begin
                    n_wr = RIDX_W'(0);
                    n_rd = RIDX_W'(0);
                end
                MODE_ABORT: begin
                    if (r_active) begin
                        n_active = 1'b0;
                        done     = 1'b1;
                        reason   = REASON_ABORT;
                    end
                end
                default: begin
                end
            endcase
        end

        if (i_cfg.ring_reset) begin
            n_wr = RIDX_W'(0);
            n_rd = RIDX_W'(0);
        end

        held_f = rrt_held(n_wr, n_rd, i_cfg.ring_size);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr        <= '0;
            r_rd        <= '0;
            r_active    <= 1'b0;
            r_count     <= 16'd0;
            r_len       <= 16'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_wr     <= n_wr;
            r_rd     <= n_rd;
            r_active <= n_active;
            r_count  <= n_count;
            r_len    <= n_len;
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_ring[r_wr] <= i_q_item.rx_byte;
        end
        if (push && (r_wr == n_rd)) begin
            r_head <= i_q_item.rx_byte;
        end else begin
            r_head <= r_ring[n_rd];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_rx_taken        <= push;
            o_deliver_valid   <= dvalid;
            o_deliver_byte    <= dbyte;
            o_request_done    <= done;
            o_done_reason     <= reason;
            o_delivered_count <= n_count;
            o_bytes_available <= held_f[5:0];
            o_request_ignored <= ignored;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule
